/* src/lz_byte_stream_decompressor_top_defines.svh */
// assertion macros for the lz byte stream decompressor
// used by files that carry concurrent assertions; no other dependencies
`ifndef LZ_BYTE_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZ_BYTE_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH

// same-cycle implication
`define LZD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LZD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lzd_pkg.sv */
// shared types and constants for the lz byte stream decompressor
// no dependencies
package lzd_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 2;
   localparam int LIMIT_W = 13;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
   localparam logic [BYTE_W-1:0]  TOKEN_MIN   = 8'h80;
   localparam logic [BYTE_W:0]    TOKEN_BASE  = 9'h100;

   localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
   localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;
   localparam logic [COUNT_W-1:0] CNT_TWO  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } lzd_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } lzd_ring_ctl_type;

endpackage

/* src/lzd_if.sv */
// valid/ready channel interfaces for compressed input and decompressed results
// depends on lzd_pkg
interface lzd_req_if;
   import lzd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzd_rsp_if;
   import lzd_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  first_byte;
   logic [BYTE_W-1:0]  second_byte;
   logic [COUNT_W-1:0] byte_count;
   logic               run_last;
   logic               full_res;
   logic               bad_distance;

   modport source (output valid, output first_byte, output second_byte, output byte_count,
                   output run_last, output full_res, output bad_distance, input ready);
   modport sink   (input valid, input first_byte, input second_byte, input byte_count,
                   input run_last, input full_res, input bad_distance, output ready);
endinterface

/* src/lzd_ring.sv */
// history ring: one write port, one registered read port
// depends on lzd_pkg
module lzd_ring #(
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  lzd_pkg::lzd_ring_ctl_type ctl,
   input  logic [AW-1:0]             wr_addr,
   input  logic [lzd_pkg::BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic [lzd_pkg::BYTE_W-1:0] rd_data
);
   import lzd_pkg::*;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/lz_byte_stream_decompressor_top.sv */
// top level of the lz byte stream decompressor: token decode, copy sequencer, result register
// depends on lzd_pkg, lzd_if, lzd_ring and the assertion macro header
//
// req_chan takes one compressed byte per transfer with in_last marking the end of a block.
// rsp_chan gives results of up to two decompressed bytes plus run_last, full_res and
// bad_distance flags. csr_wr_en/csr_wr_data write output_limit (13 bits, reset 4096).
// A literal, a rejected distance or a byte taken while full gives one result, registered in
// the cycle after the transfer; a length token gives no result.
// A match copies one byte per cycle out of the history ring unless the receiver stalls a
// result; the single registered read port of the ring fetches each source byte ahead of its
// copy step. Results carry two bytes each, the last of a run one or two. req_chan.ready stays
// low for the whole run, so the input takes no new byte until the match has been copied.
// Copies with distance one forward the byte just written around the memory.
// A stalled receiver freezes the copy in place; nothing is lost or repeated.
// Reset clears state, counters, pending and full flags and the result valid bit; the history
// ring and the result bytes are not cleared, and ring entries are only read after being
// written within the current block.
`include "lz_byte_stream_decompressor_top_defines.svh"

module lz_byte_stream_decompressor_top #(
   parameter int HISTORY_DEPTH = 256,
   parameter int MAX_OUTPUT    = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   lzd_req_if.sink                     req_chan,
   lzd_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [lzd_pkg::LIMIT_W-1:0] csr_wr_data
);
   import lzd_pkg::*;

   localparam int PTR_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(MAX_OUTPUT + 1);
   localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [LIM_W-1:0] MAX_OUT_L = LIM_W'(MAX_OUTPUT);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(HISTORY_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(HISTORY_DEPTH);

   lzd_state_type      st_ff, st_in;
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [CNT_W-1:0]   produced_ff, produced_in;
   logic [BYTE_W-1:0]  pending_ff, pending_in;
   logic               awaiting_ff, awaiting_in;
   logic               full_ff, full_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [BYTE_W-1:0]  left_ff, left_in;
   logic [PTR_W-1:0]   src_ff, src_in;
   logic               fwd_ff, fwd_in;
   logic [BYTE_W-1:0]  lastb_ff, lastb_in;
   logic               half_ff, half_in;
   logic [BYTE_W-1:0]  halfb_ff, halfb_in;
   logic               itemlast_ff, itemlast_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_first_ff, rsp_first_in;
   logic [BYTE_W-1:0]  rsp_second_ff, rsp_second_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_run_last_ff, rsp_run_last_in;
   logic               rsp_full_ff, rsp_full_in;
   logic               rsp_bad_ff, rsp_bad_in;

   lzd_ring_ctl_type   ring_ctl;
   logic [PTR_W-1:0]   ring_rd_addr;
   logic [BYTE_W-1:0]  ring_wr_data;
   logic [BYTE_W-1:0]  ring_rd_data;

   logic [LIM_W-1:0]   limit_x;
   logic [CNT_W-1:0]   lim_eff;
   logic [CNT_W:0]     prod_inc;
   logic               full_after;
   logic               full_now;
   logic               out_free;
   logic               req_take;
   logic               dist_bad;
   logic [PTR_W:0]     wp_x;
   logic [PTR_W:0]     dist_p;
   logic [PTR_W-1:0]   src_start;
   logic [PTR_W-1:0]   wp_next;
   logic [PTR_W-1:0]   src_next;
   logic [BYTE_W-1:0]  copy_byte;
   logic               run_final;
   logic               run_emit;
   logic               run_take;
   logic               lit_take;

   // effective limit and counter arithmetic
   assign limit_x    = LIM_W'(limit_ff);
   assign lim_eff    = (limit_x < MAX_OUT_L) ? CNT_W'(limit_x) : CNT_W'(MAX_OUT_L);
   assign prod_inc   = {1'b0, produced_ff} + 1'b1;
   assign full_after = prod_inc >= {1'b0, lim_eff};
   assign full_now   = full_ff || (produced_ff >= lim_eff);

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (st_ff == ST_IDLE) && out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign dist_bad = (req_chan.in_byte == '0) || (CNT_W'(req_chan.in_byte) > produced_ff);

   // ring address arithmetic with wrap at the history depth
   assign wp_x      = {1'b0, wp_ff};
   assign dist_p    = (PTR_W + 1)'(req_chan.in_byte);
   assign src_start = (wp_x >= dist_p) ? PTR_W'(wp_x - dist_p) : PTR_W'(wp_x + DEPTH_X - dist_p);
   assign wp_next   = (wp_ff == LAST_PTR) ? '0 : wp_ff + 1'b1;
   assign src_next  = (src_ff == LAST_PTR) ? '0 : src_ff + 1'b1;

   // copy step
   assign copy_byte = fwd_ff ? lastb_ff : ring_rd_data;
   assign run_final = (left_ff == BYTE_W'(1)) || full_after;
   assign run_emit  = half_ff || run_final;
   assign run_take  = (st_ff == ST_RUN) && (!run_emit || out_free);

   assign lit_take = req_take && !full_now && !awaiting_ff && (req_chan.in_byte < TOKEN_MIN);

   assign ring_wr_data = (st_ff == ST_RUN) ? copy_byte : req_chan.in_byte;
   assign ring_rd_addr = (st_ff == ST_RUN) ? src_next : src_start;

   lzd_ring #(
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .ctl     (ring_ctl),
      .wr_addr (wp_ff),
      .wr_data (ring_wr_data),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   always_comb begin
      st_in           = st_ff;
      wp_in           = wp_ff;
      produced_in     = produced_ff;
      pending_in      = pending_ff;
      awaiting_in     = awaiting_ff;
      full_in         = full_ff;
      limit_in        = csr_wr_en ? csr_wr_data : limit_ff;
      left_in         = left_ff;
      src_in          = src_ff;
      fwd_in          = fwd_ff;
      lastb_in        = lastb_ff;
      half_in         = half_ff;
      halfb_in        = halfb_ff;
      itemlast_in     = itemlast_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_first_in    = rsp_first_ff;
      rsp_second_in   = rsp_second_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_run_last_in = rsp_run_last_ff;
      rsp_full_in     = rsp_full_ff;
      rsp_bad_in      = rsp_bad_ff;
      ring_ctl        = '{wr_en: 1'b0, rd_en: 1'b0};

      unique case (st_ff)
         ST_IDLE: begin
            if (req_take) begin
               priority if (full_now) begin
                  full_in         = 1'b1;
                  rsp_valid_in    = 1'b1;
                  rsp_first_in    = '0;
                  rsp_second_in   = '0;
                  rsp_count_in    = CNT_NONE;
                  rsp_run_last_in = 1'b1;
                  rsp_full_in     = 1'b1;
                  rsp_bad_in      = 1'b0;
               end else if (awaiting_ff) begin
                  awaiting_in = 1'b0;
                  pending_in  = '0;
                  if (dist_bad) begin
                     rsp_valid_in    = 1'b1;
                     rsp_first_in    = '0;
                     rsp_second_in   = '0;
                     rsp_count_in    = CNT_NONE;
                     rsp_run_last_in = 1'b1;
                     rsp_full_in     = 1'b0;
                     rsp_bad_in      = 1'b1;
                  end else begin
                     st_in        = ST_RUN;
                     left_in      = pending_ff;
                     src_in       = src_start;
                     fwd_in       = 1'b0;
                     half_in      = 1'b0;
                     itemlast_in  = req_chan.in_last;
                     ring_ctl.rd_en = 1'b1;
                  end
               end else if (req_chan.in_byte >= TOKEN_MIN) begin
                  pending_in  = BYTE_W'(TOKEN_BASE - {1'b0, req_chan.in_byte});
                  awaiting_in = 1'b1;
               end else begin
                  ring_ctl.wr_en  = 1'b1;
                  wp_in           = wp_next;
                  produced_in     = CNT_W'(prod_inc);
                  full_in         = full_after;
                  rsp_valid_in    = 1'b1;
                  rsp_first_in    = req_chan.in_byte;
                  rsp_second_in   = '0;
                  rsp_count_in    = CNT_ONE;
                  rsp_run_last_in = 1'b1;
                  rsp_full_in     = full_after;
                  rsp_bad_in      = 1'b0;
               end
               // end of block clears the counters unless a copy is still running
               if (req_chan.in_last && (st_in == ST_IDLE)) begin
                  wp_in       = '0;
                  produced_in = '0;
                  pending_in  = '0;
                  awaiting_in = 1'b0;
                  full_in     = 1'b0;
               end
            end
         end
         ST_RUN: begin
            if (run_take) begin
               ring_ctl.wr_en = 1'b1;
               wp_in          = wp_next;
               produced_in    = CNT_W'(prod_inc);
               lastb_in       = copy_byte;
               left_in        = left_ff - 1'b1;
               if (run_emit) begin
                  half_in         = 1'b0;
                  rsp_valid_in    = 1'b1;
                  rsp_first_in    = half_ff ? halfb_ff : copy_byte;
                  rsp_second_in   = half_ff ? copy_byte : '0;
                  rsp_count_in    = half_ff ? CNT_TWO : CNT_ONE;
                  rsp_run_last_in = run_final;
                  rsp_full_in     = run_final && full_after;
                  rsp_bad_in      = 1'b0;
               end else begin
                  half_in  = 1'b1;
                  halfb_in = copy_byte;
               end
               if (run_final) begin
                  st_in   = ST_IDLE;
                  full_in = full_after;
                  if (itemlast_ff) begin
                     wp_in       = '0;
                     produced_in = '0;
                     pending_in  = '0;
                     awaiting_in = 1'b0;
                     full_in     = 1'b0;
                  end
               end else begin
                  ring_ctl.rd_en = 1'b1;
                  src_in         = src_next;
                  fwd_in         = (src_next == wp_ff);
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         wp_ff        <= '0;
         produced_ff  <= '0;
         pending_ff   <= '0;
         awaiting_ff  <= 1'b0;
         full_ff      <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         wp_ff        <= wp_in;
         produced_ff  <= produced_in;
         pending_ff   <= pending_in;
         awaiting_ff  <= awaiting_in;
         full_ff      <= full_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff         <= left_in;
      src_ff          <= src_in;
      fwd_ff          <= fwd_in;
      lastb_ff        <= lastb_in;
      half_ff         <= half_in;
      halfb_ff        <= halfb_in;
      itemlast_ff     <= itemlast_in;
      rsp_first_ff    <= rsp_first_in;
      rsp_second_ff   <= rsp_second_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_run_last_ff <= rsp_run_last_in;
      rsp_full_ff     <= rsp_full_in;
      rsp_bad_ff      <= rsp_bad_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.first_byte   = rsp_first_ff;
   assign rsp_chan.second_byte  = rsp_second_ff;
   assign rsp_chan.byte_count   = rsp_count_ff;
   assign rsp_chan.run_last     = rsp_run_last_ff;
   assign rsp_chan.full_res     = rsp_full_ff;
   assign rsp_chan.bad_distance = rsp_bad_ff;

   `LZD_ASSERT_NOW(a_run_needs_distance, clock, reset,
      $rose(st_ff == ST_RUN), $past(awaiting_ff), "copy started without a pending length")
   `LZD_ASSERT_NEXT(a_literal_counts, clock, reset,
      lit_take && !req_chan.in_last, produced_ff == CNT_W'($past(produced_ff) + 1'b1),
      "literal transfer did not advance the produced count")
   `LZD_ASSERT_NOW(a_bad_result_empty, clock, reset,
      rsp_valid_ff && rsp_bad_ff, (rsp_count_ff == CNT_NONE) && rsp_run_last_ff,
      "rejected distance result carries bytes or is not final")

endmodule
